// ----- hdl/ssfl_pkg.sv -----
// ----------------------------------------------------------------------------
// ssfl_pkg: shared types and constants for the substring search block
// Register indexes, payload widths and the pattern byte array type.
// ----------------------------------------------------------------------------
package ssfl_pkg;

  // Pattern storage: two 64-bit registers, sixteen bytes
  localparam int PAT_BYTES  = 16;
  localparam int LEN_W      = 5;
  localparam int POS_OUT_W  = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 64;

  typedef logic [7:0] byte_t;
  typedef logic [PAT_BYTES-1:0][7:0] pat_bytes_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIND_LAST      = 8'd3;

endpackage

// ----- hdl/ssfl_if.sv -----
// ----------------------------------------------------------------------------
// ssfl interfaces: text, result and configuration channels
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ssfl_text_if;
  logic          valid;
  logic          ready;
  logic [7:0]    text_byte;
  logic          last_byte;

  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

interface ssfl_result_if;
  logic          valid;
  logic          ready;
  logic          found;
  logic [15:0]   match_position;
  logic          too_long;

  modport source (output valid, output found, output match_position, output too_long,
                  input ready);
  modport sink   (input valid, input found, input match_position, input too_long,
                  output ready);
endinterface

interface ssfl_cfg_if;
  logic          valid;
  logic          ready;
  logic [7:0]    index;
  logic [63:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/ssfl_window_match.sv -----
// ----------------------------------------------------------------------------
// ssfl_window_match: parallel compare of the byte window with the pattern
// Window entry 0 is the newest byte; it lines up with the last pattern byte.
// ----------------------------------------------------------------------------
module ssfl_window_match #(
  parameter int MAX_PATTERN = 16
) (
  input  logic [MAX_PATTERN-1:0][7:0]  window,
  input  ssfl_pkg::pat_bytes_t         pattern,
  input  logic [ssfl_pkg::LEN_W-1:0]   len,
  output logic                         hit
);
  import ssfl_pkg::*;

  logic [MAX_PATTERN-1:0] pos_ok;

  // Each window slot below len is checked against pattern byte len-1-k
  always_comb begin
    logic [LEN_W-1:0] pidx;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      pidx      = len - LEN_W'(k) - LEN_W'(1);
      pos_ok[k] = (LEN_W'(k) >= len) || (window[k] == pattern[pidx[3:0]]);
    end
  end

  assign hit = &pos_ok;

endmodule

// ----- hdl/substring_search_first_or_last.sv -----
// ----------------------------------------------------------------------------
// substring_search_first_or_last: streaming pattern search over a byte text
// Reports the first (or last) start offset of a 1..16 byte pattern.
// ----------------------------------------------------------------------------
// Usage:
//   cfg    : register writes (index, data); always ready. Write only while the
//            block is idle. 0 pattern_low, 1 pattern_high, 2 pattern_length,
//            3 find_last; other indexes are ignored.
//   text   : one text byte per item, last_byte marks the end of a text.
//   result : one item per text, issued for the byte marked last, carrying
//            found, match_position and too_long.
// Throughput: one text byte per cycle, except while a final byte stalls. Each
//   byte waits in the input register while the window compare and state update
//   run; the result register loads from there, so a text's result is offered
//   once its final byte has passed the input register and the result register.
// Stalls: non-final bytes never wait on the result side. A final byte waits
//   in the input register only while the result register holds an untaken
//   item; text.ready then drops until the result is taken.
// Reset: rst (synchronous) clears the window, byte count, match record and the
//   valid bits of both channel registers, and loads the register defaults
//   (length 1, find-first, pattern all zero).
// ----------------------------------------------------------------------------
module substring_search_first_or_last #(
  parameter int MAX_PATTERN   = 16,
  parameter int POSITION_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  ssfl_cfg_if.sink      cfg,
  ssfl_text_if.sink     text,
  ssfl_result_if.source result
);
  import ssfl_pkg::*;

  localparam int CW = POSITION_BITS + 1;

  // Configuration registers
  logic [63:0]      pattern_low;
  logic [63:0]      pattern_high;
  logic [LEN_W-1:0] pattern_length;
  logic             find_last;

  // Input register
  logic             in_valid;
  byte_t            in_byte;
  logic             in_last;

  // Search state
  logic [MAX_PATTERN-1:0][7:0] window;
  logic [CW-1:0]               bytes_seen;
  logic                        match_seen;
  logic [POSITION_BITS-1:0]    match_start;

  // Result register
  logic                 out_valid;
  logic                 out_found;
  logic [POS_OUT_W-1:0] out_position;
  logic                 out_too_long;

  logic                        adv;
  logic [LEN_W-1:0]            len;
  logic [MAX_PATTERN-1:0][7:0] window_next;
  logic                        hit;
  logic                        eligible;
  logic                        saturated;
  logic [CW-1:0]               start;
  logic                        record;
  logic [CW-1:0]               bytes_seen_next;
  logic                        match_seen_next;
  logic [POSITION_BITS-1:0]    match_start_next;
  logic [POSITION_BITS+POS_OUT_W-1:0] start_ext;
  pat_bytes_t                  pattern;

  // Configuration writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= LEN_W'(1);
      find_last      <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_PATTERN_LOW:    pattern_low    <= cfg.data;
        REG_PATTERN_HIGH:   pattern_high   <= cfg.data;
        REG_PATTERN_LENGTH: pattern_length <= cfg.data[LEN_W-1:0];
        REG_FIND_LAST:      find_last      <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // Handshake: a final byte needs the result register free
  assign adv        = in_valid && (!in_last || !out_valid || result.ready);
  assign text.ready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (text.valid && text.ready) begin
      in_valid <= 1'b1;
    end else if (adv) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      in_byte <= text.text_byte;
      in_last <= text.last_byte;
    end
  end

  // Effective pattern length, clamped to 1..MAX_PATTERN
  always_comb begin
    if (pattern_length == '0) begin
      len = LEN_W'(1);
    end else if (pattern_length > LEN_W'(MAX_PATTERN)) begin
      len = LEN_W'(MAX_PATTERN);
    end else begin
      len = pattern_length;
    end
  end

  // Window after shifting in the new byte
  always_comb begin
    window_next[0] = in_byte;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      window_next[k] = window[k-1];
    end
  end

  assign pattern = {pattern_high, pattern_low};

  ssfl_window_match #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_match (
    .window  (window_next),
    .pattern (pattern),
    .len     (len),
    .hit     (hit)
  );

  // Match bookkeeping for the current byte
  assign saturated = &bytes_seen;
  assign eligible  = ({1'b0, bytes_seen} + (CW+1)'(1)) >= (CW+1)'(len);
  assign start     = bytes_seen + CW'(1) - CW'(len);
  assign record    = hit && eligible && !saturated && !start[CW-1]
                     && (find_last || !match_seen);

  always_comb begin
    bytes_seen_next  = saturated ? bytes_seen : bytes_seen + CW'(1);
    match_seen_next  = match_seen || record;
    match_start_next = record ? start[POSITION_BITS-1:0] : match_start;
  end

  assign start_ext = {{POS_OUT_W{1'b0}}, match_start_next};

  // State update; a final byte clears the text state
  always_ff @(posedge clk) begin
    if (rst) begin
      window      <= '0;
      bytes_seen  <= '0;
      match_seen  <= 1'b0;
      match_start <= '0;
    end else if (adv) begin
      if (in_last) begin
        window      <= '0;
        bytes_seen  <= '0;
        match_seen  <= 1'b0;
        match_start <= '0;
      end else begin
        window      <= window_next;
        bytes_seen  <= bytes_seen_next;
        match_seen  <= match_seen_next;
        match_start <= match_start_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && in_last) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_last) begin
      out_found    <= match_seen_next;
      out_position <= match_seen_next ? start_ext[POS_OUT_W-1:0] : '0;
      out_too_long <= bytes_seen_next[CW-1] && (bytes_seen_next[CW-2:0] != '0);
    end
  end

  assign result.valid          = out_valid;
  assign result.found          = out_found;
  assign result.match_position = out_position;
  assign result.too_long       = out_too_long;

  // Checks
  a_no_match_zero_pos: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.found |-> result.match_position == '0)
    else $error("match_position nonzero without a match");

  a_idle_start_zero: assert property (@(posedge clk) disable iff (rst)
    !match_seen |-> match_start == '0)
    else $error("match_start set without a recorded match");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    adv && in_last |=> bytes_seen == '0 && !match_seen)
    else $error("text state not cleared after final byte");

  a_stall_reason: assert property (@(posedge clk) disable iff (rst)
    !text.ready |-> in_valid && in_last && out_valid && !result.ready)
    else $error("input stalled without a blocked final byte");

endmodule
